// File: rtl/core/zero_crossing_time_interpolator_macros.svh
// Assertion macros for the zero-crossing time interpolator.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ZERO_CROSSING_TIME_INTERPOLATOR_MACROS_SVH
`define ZERO_CROSSING_TIME_INTERPOLATOR_MACROS_SVH

// Checked outside reset only.
`define ZCTI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define ZCTI_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/zcti_pkg.sv
// Shared types and constants of the zero-crossing time interpolator.
// No dependencies; used by zcti_interp and the top level.
`default_nettype none

package zcti_pkg;

  localparam int unsigned MAX_CROSSINGS = 8;
  localparam int unsigned FRACTION_BITS = 8;

  localparam int unsigned ADC_W   = 12;
  localparam int unsigned DEV_W   = ADC_W + 1;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CTIME_W = 40;
  localparam int unsigned NUM_W6  = 6;
  localparam int unsigned FOUND_W = 7;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_REFERENCE    = 2'd0;
  localparam logic [1:0] REG_WINDOW_START = 2'd1;
  localparam logic [1:0] REG_WINDOW_END   = 2'd2;

  localparam logic [ADC_W-1:0]  REFERENCE_RST    = 12'd2048;
  localparam logic [TIME_W-1:0] WINDOW_START_RST = '0;
  localparam logic [TIME_W-1:0] WINDOW_END_RST   = '1;

  typedef struct packed {
    logic [ADC_W-1:0]  sample_value;
    logic [TIME_W-1:0] sample_time;
    logic              frame_last;
  } in_t;

  typedef struct packed {
    logic [CTIME_W-1:0] crossing_time;
    logic [NUM_W6-1:0]  crossing_number;
    logic [FOUND_W-1:0] crossing_count;
    logic               is_summary;
    logic               last;
  } out_t;

  // Top-level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_CROSS,
    ST_SUM
  } ctrl_state_e;

  // Interpolation unit
  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_FIN
  } unit_state_e;

  typedef struct packed {
    logic              start;
    logic [ADC_W-1:0]  a0;   // |earlier deviation|
    logic [ADC_W-1:0]  a1;   // |later deviation|
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t1;
  } interp_req_t;

  typedef struct packed {
    logic               done;
    logic [CTIME_W-1:0] crossing_time;
  } interp_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/zcti_interp.sv
// Bit-serial interpolation unit: shift-add multiply, then restoring divide.
// Depends on zcti_pkg.
`default_nettype none

module zcti_interp #(
  parameter int unsigned FractionBits = zcti_pkg::FRACTION_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire zcti_pkg::interp_req_t req_i,
  output zcti_pkg::interp_rsp_t      rsp_o
);
  import zcti_pkg::*;

  localparam int unsigned PROD_W = TIME_W + ADC_W;
  localparam int unsigned NUM_W  = PROD_W + FractionBits;
  localparam int unsigned QUO_W  = TIME_W + FractionBits;
  localparam int unsigned CNT_W  = $clog2(NUM_W);

  unit_state_e state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;

  logic [TIME_W-1:0]  dt_q;
  logic [TIME_W-1:0]  t1_q;
  logic               back_q;   // t1 < t0
  logic [ADC_W-1:0]   a1_q;
  logic [DEV_W-1:0]   den_q;
  logic [NUM_W-1:0]   num_q;
  logic [DEV_W-1:0]   rem_q;
  logic [QUO_W-1:0]   quo_q;
  logic [CTIME_W-1:0] res_q;

  logic [NUM_W-1:0]   mul_sum;
  logic [DEV_W:0]     rem_sh;
  logic [DEV_W:0]     rem_sub;
  logic               qbit;
  logic [CTIME_W-1:0] base;
  logic [CTIME_W-1:0] q_ext;
  logic [CTIME_W-1:0] res_d;

  // one multiplier bit per cycle, MSB first
  assign mul_sum = (num_q << 1) + (a1_q[ADC_W-1] ? NUM_W'(dt_q) : '0);

  // one quotient bit per cycle
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign qbit    = (rem_sh >= {1'b0, den_q});

  // forward pair: base - ceil(q); backward pair: base + floor(q)
  assign base  = CTIME_W'(t1_q) << FractionBits;
  assign q_ext = CTIME_W'(quo_q);
  assign res_d = back_q ? (base + q_ext)
                        : (base + ~q_ext + CTIME_W'(rem_q == '0));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          state_d = U_MUL;
          cnt_d   = CNT_W'(ADC_W - 1);
        end
      end
      U_MUL: begin
        if (cnt_q == '0) begin
          state_d = U_DIV;
          cnt_d   = CNT_W'(NUM_W - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      U_DIV: begin
        if (cnt_q == '0) begin
          state_d = U_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      U_FIN: begin
        state_d = U_IDLE;
        done_d  = 1'b1;
      end
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          back_q <= (req_i.t1 < req_i.t0);
          dt_q   <= (req_i.t1 < req_i.t0) ? (req_i.t0 - req_i.t1)
                                           : (req_i.t1 - req_i.t0);
          t1_q   <= req_i.t1;
          a1_q   <= req_i.a1;
          den_q  <= {1'b0, req_i.a0} + {1'b0, req_i.a1};
          num_q  <= '0;
          rem_q  <= '0;
          quo_q  <= '0;
        end
      end
      U_MUL: begin
        a1_q  <= a1_q << 1;
        num_q <= (cnt_q == '0) ? (mul_sum << FractionBits) : mul_sum;
      end
      U_DIV: begin
        num_q <= num_q << 1;
        rem_q <= qbit ? rem_sub[DEV_W-1:0] : rem_sh[DEV_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], qbit};
      end
      U_FIN: begin
        res_q <= res_d;
      end
      default: ;
    endcase
  end

  assign rsp_o.done          = done_q;
  assign rsp_o.crossing_time = res_q;

endmodule

`default_nettype wire

// File: rtl/core/zero_crossing_time_interpolator.sv
// A crossing result follows its sample transaction through the serial multiply, the serial
//   divide, then the handoff to the output register.
// A summary with no crossing ahead of it goes through ST_SUM into the output register.
// Throughput: one sample per cycle with no result; a sample that brings a crossing or a
//   summary holds off the next one until its results are loaded.
// Reset (rst_ni low, async): default registers, frame state cleared, no result pending.
`default_nettype none
`include "zero_crossing_time_interpolator_macros.svh"

module zero_crossing_time_interpolator #(
  parameter int unsigned MaxCrossings = zcti_pkg::MAX_CROSSINGS,
  parameter int unsigned FractionBits = zcti_pkg::FRACTION_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // sample stream
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire zcti_pkg::in_t                     in_data_i,
  // result stream
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output zcti_pkg::out_t                         out_data_o,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [zcti_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [zcti_pkg::PDATA_W-1:0]      pwdata,
  output logic [zcti_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready
);
  import zcti_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ADC_W-1:0]  ref_q;
  logic [TIME_W-1:0] wstart_q;
  logic [TIME_W-1:0] wend_q;
  logic [1:0]        reg_idx;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      REG_REFERENCE:    prdata = PDATA_W'(ref_q);
      REG_WINDOW_START: prdata = wstart_q;
      REG_WINDOW_END:   prdata = wend_q;
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Frame state and sequencer
  // ---------------------------------------------------------------------------
  ctrl_state_e state_q, state_d;

  logic signed [DEV_W-1:0] prev_dev_q;
  logic [TIME_W-1:0]       prev_time_q;
  logic [FOUND_W-1:0]      found_q;
  logic                    have_prev_q;
  logic                    stopped_q;

  // what the accepted transaction still owes downstream
  logic [NUM_W6-1:0]       cross_num_q;
  logic [FOUND_W-1:0]      sum_cnt_q;
  logic                    want_sum_q;

  out_t out_q;
  logic out_valid_q;

  logic                    in_accept;
  logic signed [DEV_W-1:0] dev;
  logic [DEV_W-1:0]        dev_neg;
  logic [DEV_W-1:0]        prev_neg;
  logic                    dev_pos, dev_is_neg, prev_pos, prev_is_neg;
  logic                    pair_live, in_window, past_end, sign_flip;
  logic                    below_max, emit, stop_set;
  logic [FOUND_W-1:0]      found_next;
  logic                    out_free, load_cross, load_sum;
  interp_req_t             ireq;
  interp_rsp_t             irsp;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // deviation of the new sample from the zero line, 13-bit signed
  assign dev = signed'({1'b0, in_data_i.sample_value}) - signed'({1'b0, ref_q});
  assign dev_neg  = -dev;
  assign prev_neg = -prev_dev_q;

  // a zero deviation counts as neither sign, so it never forms a crossing
  assign dev_is_neg  = dev[DEV_W-1];
  assign dev_pos     = !dev[DEV_W-1] && (dev != '0);
  assign prev_is_neg = prev_dev_q[DEV_W-1];
  assign prev_pos    = !prev_dev_q[DEV_W-1] && (prev_dev_q != '0);
  assign sign_flip   = (prev_is_neg && dev_pos) || (prev_pos && dev_is_neg);

  // window start is checked first: a skipped pair never stops the frame
  assign pair_live = have_prev_q && !stopped_q;
  assign in_window = !(prev_time_q < wstart_q);
  assign past_end  = prev_time_q > wend_q;
  assign below_max = found_q < FOUND_W'(MaxCrossings);

  assign emit     = pair_live && in_window && !past_end && sign_flip && below_max;
  assign stop_set = pair_live && in_window &&
                    (past_end || (sign_flip && !below_max));
  assign found_next = found_q + FOUND_W'(emit);

  // magnitudes of both deviations and the pair's times go to the serial unit
  always_comb begin
    ireq.start = in_accept && emit;
    ireq.a0    = prev_is_neg ? prev_neg[ADC_W-1:0] : prev_dev_q[ADC_W-1:0];
    ireq.a1    = dev_is_neg ? dev_neg[ADC_W-1:0] : dev[ADC_W-1:0];
    ireq.t0    = prev_time_q;
    ireq.t1    = in_data_i.sample_time;
  end

  zcti_interp #(
    .FractionBits(FractionBits)
  ) u_interp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ireq),
    .rsp_o (irsp)
  );

  // the output register frees up in the cycle its transaction completes
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    load_cross = 1'b0;
    load_sum   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (emit) begin
            state_d = ST_CALC;
          end else if (in_data_i.frame_last) begin
            state_d = ST_SUM;
          end
        end
      end
      ST_CALC: begin
        if (irsp.done) begin
          state_d = ST_CROSS;
        end
      end
      ST_CROSS: begin
        if (out_free) begin
          load_cross = 1'b1;
          state_d    = want_sum_q ? ST_SUM : ST_IDLE;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          load_sum = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q       <= REFERENCE_RST;
      wstart_q    <= WINDOW_START_RST;
      wend_q      <= WINDOW_END_RST;
      state_q     <= ST_IDLE;
      prev_dev_q  <= '0;
      prev_time_q <= '0;
      found_q     <= '0;
      have_prev_q <= 1'b0;
      stopped_q   <= 1'b0;
      want_sum_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_write) begin
        case (reg_idx)
          REG_REFERENCE:    ref_q    <= pwdata[ADC_W-1:0];
          REG_WINDOW_START: wstart_q <= pwdata;
          REG_WINDOW_END:   wend_q   <= pwdata;
          default: ;
        endcase
      end

      if (in_accept) begin
        want_sum_q <= in_data_i.frame_last;
        if (in_data_i.frame_last) begin
          // frame closes: the frame state goes back to its reset value
          prev_dev_q  <= '0;
          prev_time_q <= '0;
          found_q     <= '0;
          have_prev_q <= 1'b0;
          stopped_q   <= 1'b0;
        end else begin
          prev_dev_q  <= dev;
          prev_time_q <= in_data_i.sample_time;
          found_q     <= found_next;
          have_prev_q <= 1'b1;
          stopped_q   <= stopped_q || stop_set;
        end
      end

      if (load_cross || load_sum) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cross_num_q <= found_q[NUM_W6-1:0];
      sum_cnt_q   <= found_next;
    end
    if (load_cross) begin
      out_q.crossing_time   <= irsp.crossing_time;
      out_q.crossing_number <= cross_num_q;
      out_q.crossing_count  <= '0;
      out_q.is_summary      <= 1'b0;
      out_q.last            <= !want_sum_q;
    end else if (load_sum) begin
      out_q.crossing_time   <= '0;
      out_q.crossing_number <= '0;
      out_q.crossing_count  <= sum_cnt_q;
      out_q.is_summary      <= 1'b1;
      out_q.last            <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ZCTI_ASSERT(a_found_bound, found_q <= FOUND_W'(MaxCrossings), "crossing count over limit")
  `ZCTI_ASSERT(a_start_to_calc, ireq.start |=> state_q == ST_CALC, "unit started outside wait")
  `ZCTI_ASSERT_ALWAYS(a_done_in_calc, irsp.done |-> state_q == ST_CALC, "stray unit done")

endmodule

`default_nettype wire
